// ===== rtl/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

   // Result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_NOSPACE = 3'd2;
   localparam logic [2:0] ST_NOSLOT  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   // Request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // Register indexes (taken from paddr[2])
   localparam logic CSR_IDX_BASE  = 1'b0;
   localparam logic CSR_IDX_LIMIT = 1'b1;

   // Register reset values
   localparam logic [31:0] HEAP_BASE_RESET  = 32'h0010_0000;
   localparam logic [31:0] HEAP_LIMIT_RESET = 32'h0040_0000;

   // One block slot as stored in the slot table
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
      logic        free;
      logic        live;
   } slot_type;

   // Result of the size rounding unit
   typedef struct packed {
      logic        done;
      logic [32:0] size;
   } round_type;

endpackage

// ===== rtl/ffha_round.sv =====
// Size rounding unit: rounds a request up to a multiple of the alignment.
module ffha_round #(
   parameter int ALIGN_BYTES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         value,
   output ffha_pkg::round_type rnd
);
   import ffha_pkg::*;

   localparam bit          POW2    = (ALIGN_BYTES & (ALIGN_BYTES - 1)) == 0;
   localparam int          SHIFT   = 32 + $clog2(ALIGN_BYTES);
   localparam logic [63:0] ONE64   = 64'd1;
   localparam logic [63:0] RECIP64 = ((ONE64 << SHIFT) + 64'(ALIGN_BYTES) - 64'd1)
                                     / 64'(ALIGN_BYTES);
   localparam logic [32:0] RECIP_V = RECIP64[32:0];
   localparam logic [32:0] ALIGN_V = 33'(ALIGN_BYTES);
   localparam logic [32:0] MASK_V  = ~(ALIGN_V - 33'd1);
   localparam logic [31:0] ALIGN_W = 32'(ALIGN_BYTES);

   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;
   logic        done_ff, done_in;
   logic [31:0] val_ff, val_in;
   logic [64:0] prod_ff, prod_in;
   logic [32:0] size_ff, size_in;
   logic [31:0] quot;
   logic [31:0] rem;

   always_comb begin
      busy_in = 1'b0;
      fin_in  = 1'b0;
      done_in = 1'b0;
      val_in  = val_ff;
      prod_in = prod_ff;
      size_in = size_ff;
      quot    = 32'(prod_ff >> SHIFT);
      rem     = val_ff - quot * ALIGN_W;
      if (start) begin
         val_in = value;
         if (POW2) begin
            size_in = ({1'b0, value} + ALIGN_V - 33'd1) & MASK_V;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // multiply by the scaled reciprocal; the quotient sits above SHIFT
         prod_in = 65'(val_ff) * 65'(RECIP_V);
         fin_in  = 1'b1;
      end else if (fin_ff) begin
         if (rem == '0) begin
            size_in = {1'b0, val_ff};
         end else begin
            size_in = {1'b0, val_ff} + (ALIGN_V - {1'b0, rem});
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      prod_ff <= prod_in;
      size_ff <= size_in;
   end

   assign rnd.done = done_ff;
   assign rnd.size = size_ff;

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with forward coalescing.
// Allocate: accept, size rounding, slot scan (one slot a cycle), then, with no fit,
//   the carve and limit check states (S_CARVE, S_CHECK), and the output hand-off.
// Free: accept, pointer scan, next-live scan over the rest of the table, a merge
//   write when the next live block is free, and the output hand-off. One word in flight at a time;
//   the slot table's single read port sets the scan rate.
// Reset (synchronous): slot count 0, heap top at heap base, registers at defaults;
//   the slot table itself is not cleared, entries at or above the count are never examined.
module first_fit_heap_allocator_top #(
   parameter int MAX_SLOTS    = 64,
   parameter int HEADER_BYTES = 12,
   parameter int ALIGN_BYTES  = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] req_size, [63:32] data_address
   input  logic        req_tuser,   // [0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_address, [34:32] status,
                                    // [35] merged, [39:36] zero
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ffha_pkg::*;

   localparam int          IDX_W = $clog2(MAX_SLOTS);
   localparam int          CNT_W = $clog2(MAX_SLOTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);
   localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
   localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
   localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ROUND = 4'd1;
   localparam logic [3:0] S_ASCAN = 4'd2;
   localparam logic [3:0] S_CARVE = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_FSCAN = 4'd5;
   localparam logic [3:0] S_NSCAN = 4'd6;
   localparam logic [3:0] S_MERGE = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             chk_ff, chk_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [31:0]      base_ff, base_in;
   logic [31:0]      limit_ff, limit_in;
   logic [31:0]      top_ff, top_in;
   logic [31:0]      addr_ff, addr_in;
   logic [32:0]      need_ff, need_in;
   logic [33:0]      end_ff, end_in;
   slot_type         hold_ff, hold_in;
   logic [IDX_W-1:0] hold_idx_ff, hold_idx_in;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic             res_merged_ff, res_merged_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_addr_ff, rsp_addr_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_merged_ff, rsp_merged_in;

   // slot table: one write and one registered read a cycle
   slot_type         slot_mem_ff [MAX_SLOTS];
   slot_type         rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_type         wr_data;

   logic      rnd_start;
   round_type rnd;
   logic      req_accept;
   logic      csr_write;
   logic      scan_more;
   logic      a_hit, f_hit;

   ffha_round #(
      .ALIGN_BYTES(ALIGN_BYTES)
   ) u_round (
      .clock (clock),
      .reset (reset),
      .start (rnd_start),
      .value (req_tdata[31:0]),
      .rnd   (rnd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[2])
         CSR_IDX_BASE:  csr_prdata = base_ff;
         CSR_IDX_LIMIT: csr_prdata = limit_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // compare logic on the word just read from the table
   assign scan_more = (idx_ff < count_ff);
   assign a_hit = rd_data_ff.live && rd_data_ff.free && ({1'b0, rd_data_ff.size} >= need_ff);
   assign f_hit = rd_data_ff.live && (({1'b0, rd_data_ff.start} + HDR33) == {1'b0, addr_ff});

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      chk_in        = 1'b0;
      chk_idx_in    = chk_idx_ff;
      base_in       = base_ff;
      limit_in      = limit_ff;
      top_in        = top_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      end_in        = end_ff;
      hold_in       = hold_ff;
      hold_idx_in   = hold_idx_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      res_merged_in = res_merged_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_merged_in = rsp_merged_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_data       = rd_data_ff;
      rnd_start     = 1'b0;

      // the user must write the registers only while the sequencer is idle; the block does not enforce it
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_IDX_BASE: begin
               base_in = csr_pwdata;
               if (count_ff == '0) begin
                  top_in = csr_pwdata;
               end
            end
            CSR_IDX_LIMIT: limit_in = csr_pwdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_addr_in   = '0;
               res_status_in = ST_OK;
               res_merged_in = 1'b0;
               idx_in        = '0;
               addr_in       = req_tdata[63:32];
               if (req_tuser == KIND_ALLOC) begin
                  if (req_tdata[31:0] == '0) begin
                     res_status_in = ST_ZERO;
                     state_in      = S_DONE;
                  end else begin
                     rnd_start = 1'b1;
                     state_in  = S_ROUND;
                  end
               end else begin
                  // a null pointer frees nothing
                  if (req_tdata[63:32] == '0) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FSCAN;
                  end
               end
            end
         end
         S_ROUND: begin
            if (rnd.done) begin
               need_in = rnd.size;
               idx_in  = '0;
               // an overflowed size can fit no slot: skip straight to carving
               state_in = rnd.size[32] ? S_CARVE : S_ASCAN;
            end
         end
         S_ASCAN: begin
            if (chk_ff && a_hit) begin
               // reuse the whole block, no split
               wr_en         = 1'b1;
               wr_addr       = chk_idx_ff;
               wr_data       = rd_data_ff;
               wr_data.free  = 1'b0;
               res_addr_in   = rd_data_ff.start + HDR32;
               res_status_in = ST_OK;
               state_in      = S_DONE;
            end else if (scan_more) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end else if (!chk_ff) begin
               state_in = S_CARVE;
            end
         end
         S_CARVE: begin
            if (count_ff >= MAX_CNT) begin
               res_status_in = ST_NOSLOT;
               state_in      = S_DONE;
            end else if (need_ff[32]) begin
               res_status_in = ST_NOSPACE;
               state_in      = S_DONE;
            end else begin
               end_in   = {2'b00, top_ff} + HDR34 + {1'b0, need_ff};
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (end_ff > {2'b00, limit_ff}) begin
               res_status_in = ST_NOSPACE;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = count_ff[IDX_W-1:0];
               wr_data.start = top_ff;
               wr_data.size  = need_ff[31:0];
               wr_data.free  = 1'b0;
               wr_data.live  = 1'b1;
               count_in      = count_ff + 1'b1;
               top_in        = end_ff[31:0];
               res_addr_in   = top_ff + HDR32;
               res_status_in = ST_OK;
            end
            state_in = S_DONE;
         end
         S_FSCAN: begin
            if (chk_ff && f_hit) begin
               // hold the freed slot, look for the next live one
               hold_in     = rd_data_ff;
               hold_idx_in = chk_idx_ff;
               idx_in      = CNT_W'(chk_idx_ff) + 1'b1;
               state_in    = S_NSCAN;
            end else if (scan_more) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end else if (!chk_ff) begin
               res_status_in = ST_UNKNOWN;
               state_in      = S_DONE;
            end
         end
         S_NSCAN: begin
            if (chk_ff && rd_data_ff.live) begin
               wr_en         = 1'b1;
               wr_addr       = hold_idx_ff;
               wr_data       = hold_ff;
               wr_data.free  = 1'b1;
               if (rd_data_ff.free) begin
                  // absorb the following block; retire its slot next cycle
                  wr_data.size  = hold_ff.size + HDR32 + rd_data_ff.size;
                  hold_in       = rd_data_ff;
                  hold_in.live  = 1'b0;
                  hold_idx_in   = chk_idx_ff;
                  state_in      = S_MERGE;
               end else begin
                  state_in = S_DONE;
               end
            end else if (scan_more) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end else if (!chk_ff) begin
               wr_en        = 1'b1;
               wr_addr      = hold_idx_ff;
               wr_data      = hold_ff;
               wr_data.free = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_MERGE: begin
            wr_en         = 1'b1;
            wr_addr       = hold_idx_ff;
            wr_data       = hold_ff;
            res_merged_in = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hand the word to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               rsp_merged_in = res_merged_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_ff       <= 1'b0;
         base_ff      <= HEAP_BASE_RESET;
         limit_ff     <= HEAP_LIMIT_RESET;
         top_ff       <= HEAP_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_ff       <= chk_in;
         base_ff      <= base_in;
         limit_ff     <= limit_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      end_ff        <= end_in;
      hold_ff       <= hold_in;
      hold_idx_ff   <= hold_idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      res_merged_ff <= res_merged_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_merged_ff, rsp_status_ff, rsp_addr_ff};

endmodule

// ===== test/first_fit_heap_allocator_top_tb.sv =====
// Self-checking testbench for the first-fit heap allocator: directed and random traffic.
module first_fit_heap_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ffha_pkg::*;

   // Geometry of the block as built (default parameters)
   localparam int SLOTS = 64;
   localparam int HDR   = 12;
   localparam int ALIGN = 8;

   // Run control
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int RX_HOLD_CYCLES = 400;
   // Wait after the last reply before the end of the run
   localparam int DRAIN_CYCLES   = 200;

   // One response word as the block should produce it
   typedef struct packed {
      logic [31:0] address;
      logic [2:0]  status;
      logic        merged;
   } heap_reply_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;   // [31:0] req_size, [63:32] data_address
   logic        req_tuser   = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] result_address, [34:32] status, [35] merged
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the allocator: slot table, carve pointer and registers
   logic [31:0] blk_start [SLOTS];
   logic [31:0] blk_size  [SLOTS];
   bit          blk_free  [SLOTS];
   bit          blk_live  [SLOTS];
   int          blk_count = 0;
   logic [31:0] carve_top = HEAP_BASE_RESET;
   logic [31:0] cfg_base  = HEAP_BASE_RESET;
   logic [31:0] cfg_limit = HEAP_LIMIT_RESET;

   heap_reply_type expected_replies [$];
   int             error_count = 0;

   // Traffic shaping, written only by the stimulus process
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_toggle = 1'b0;

   // Owned by the response-side ready process
   bit hold_seen = 1'b0;
   int hold_left = 0;

   first_fit_heap_allocator_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the reply for one accepted request word and advance the shadow state.
   function automatic heap_reply_type predict_reply(input logic kind, input logic [31:0] size,
                                                    input logic [31:0] addr);
      heap_reply_type    res;
      longint unsigned   rounded;
      longint unsigned   span_end;
      int                i;
      int                j;
      bit                found;
      res = '0;
      res.status = ST_OK;
      found = 1'b0;
      if (kind == KIND_ALLOC) begin
         if (size == 32'd0) begin
            res.status = ST_ZERO;
         end else begin
            rounded = ((longint'(size) + ALIGN - 1) / ALIGN) * ALIGN;
            // First fit: take the whole block, never split it
            if (rounded <= 64'hFFFF_FFFF) begin
               for (i = 0; i < blk_count && !found; i++) begin
                  if (blk_live[i] && blk_free[i] && blk_size[i] >= rounded) begin
                     blk_free[i] = 1'b0;
                     res.address = blk_start[i] + HDR;
                     found = 1'b1;
                  end
               end
            end
            if (!found) begin
               span_end = longint'(carve_top) + HDR + rounded;
               // A full table wins over a lack of space
               if (blk_count >= SLOTS) begin
                  res.status = ST_NOSLOT;
               end else if (rounded > 64'hFFFF_FFFF || span_end > cfg_limit) begin
                  res.status = ST_NOSPACE;
               end else begin
                  blk_start[blk_count] = carve_top;
                  blk_size[blk_count]  = rounded[31:0];
                  blk_free[blk_count]  = 1'b0;
                  blk_live[blk_count]  = 1'b1;
                  res.address = carve_top + HDR;
                  blk_count++;
                  carve_top = span_end[31:0];
               end
            end
         end
      end else if (addr != 32'd0) begin
         for (i = 0; i < blk_count && !found; i++) begin
            if (blk_live[i] && longint'(blk_start[i]) + HDR == longint'(addr)) begin
               found = 1'b1;
            end
         end
         if (!found) begin
            res.status = ST_UNKNOWN;
         end else begin
            i--;
            blk_free[i] = 1'b1;
            // Merge forward only with the next live block, and only if it is free
            for (j = i + 1; j < blk_count && !blk_live[j]; j++);
            if (j < blk_count && blk_free[j]) begin
               blk_size[i] = blk_size[i] + HDR + blk_size[j];
               blk_live[j] = 1'b0;
               res.merged = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Pick a random live block that is free or in use; -1 when there is none.
   function automatic int pick_slot(input bit want_free);
      int n;
      int k;
      int i;
      n = 0;
      for (i = 0; i < blk_count; i++) begin
         if (blk_live[i] && blk_free[i] == want_free) n++;
      end
      if (n == 0) return -1;
      k = $urandom_range(n - 1);
      for (i = 0; i < blk_count; i++) begin
         if (blk_live[i] && blk_free[i] == want_free) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   // Offer one request word, hold it until accepted, then record its reply.
   task automatic send_word(input logic kind, input logic [31:0] size, input logic [31:0] addr);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {addr, size};
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(predict_reply(kind, size, addr));
   endtask

   // Drop valid and wait until every outstanding reply has come back.
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // Read both registers, then write and read back each; reads check the shadow copy.
   task automatic set_heap_window(input logic [31:0] base, input logic [31:0] limit);
      logic        wr;
      logic        idx;
      logic [31:0] wdata;
      logic [31:0] mirror;
      int          t;
      for (t = 0; t < 6; t++) begin
         wr    = (t == 2 || t == 4);
         idx   = (t == 1 || t >= 4) ? CSR_IDX_LIMIT : CSR_IDX_BASE;
         wdata = (idx == CSR_IDX_BASE) ? base : limit;
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= wr;
         csr_paddr   <= {idx, 2'b00};
         csr_pwdata  <= wdata;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         mirror = (idx == CSR_IDX_BASE) ? cfg_base : cfg_limit;
         if (wr) begin
            if (idx == CSR_IDX_BASE) begin
               cfg_base = wdata;
               // The carve pointer follows the base only on an empty heap
               if (blk_count == 0) carve_top = wdata;
            end else begin
               cfg_limit = wdata;
            end
         end else if (csr_prdata !== mirror) begin
            $error("csr_prdata[%0d]: expected %h, got %h", idx, mirror, csr_prdata);
            error_count++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly well-formed allocate/free traffic against live blocks, some noise.
   task automatic send_random_item();
      int          roll;
      int          s;
      int          nfree;
      int          nused;
      int          i;
      logic [31:0] size;
      logic [31:0] addr;
      nfree = 0;
      nused = 0;
      for (i = 0; i < blk_count; i++) begin
         if (blk_live[i] && blk_free[i]) nfree++;
         if (blk_live[i] && !blk_free[i]) nused++;
      end
      size = $urandom;
      addr = $urandom;
      roll = $urandom_range(99);
      if (roll < 6) begin
         case ($urandom_range(4))
            0: send_word(KIND_ALLOC, 32'd0, addr);
            1: send_word(KIND_ALLOC, size, addr);
            2: send_word(KIND_FREE, size, 32'd0);
            3: send_word(KIND_FREE, size, addr);
            default: begin
               // Pointer inside a live block, not at its data start
               s = pick_slot(1'b0);
               if (s < 0) s = pick_slot(1'b1);
               send_word(KIND_FREE, size, (s < 0) ? addr : blk_start[s] + HDR + 4);
            end
         endcase
      end else if (nused == 0 || $urandom_range(99) < ((nfree > nused) ? 75 : 45)) begin
         s = pick_slot(1'b1);
         case ($urandom_range(9))
            6:       size = $urandom_range(65, 600);
            7, 8:    size = (s < 0) ? 32'd24 : blk_size[s];       // exact fit
            9:       size = (s < 0) ? 32'd40 : blk_size[s] + 1;   // one byte too big
            default: size = $urandom_range(1, 64);
         endcase
         send_word(KIND_ALLOC, size, addr);
      end else begin
         // Now and then free a block that is already free
         s = ($urandom_range(99) < 15) ? pick_slot(1'b1) : -1;
         if (s < 0) s = pick_slot(1'b0);
         send_word(KIND_FREE, size, blk_start[s] + HDR);
      end
   endtask

   task automatic test_directed_cases();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // Empty heap: the carve pointer moves to the new base
      set_heap_window(32'h0000_0000, 32'hFFFF_FFFF);
      send_word(KIND_ALLOC, 32'd0, 32'hFFFF_FFFF);          // zero request
      send_word(KIND_ALLOC, 32'd1, 32'h0000_0000);          // rounds up to 8
      send_word(KIND_ALLOC, 32'd9, 32'h0000_0000);          // rounds up to 16
      send_word(KIND_ALLOC, 32'd8, 32'h0000_0000);
      send_word(KIND_FREE, 32'hFFFF_FFFF, 32'd0);           // null free
      send_word(KIND_FREE, 32'd0, blk_start[0] + HDR + 1);  // unknown pointer
      send_word(KIND_FREE, 32'd0, 32'hFFFF_FFFF);
      send_word(KIND_FREE, 32'd0, blk_start[1] + HDR);      // next block busy, no merge
      send_word(KIND_FREE, 32'd0, blk_start[0] + HDR);      // absorbs the second block
      send_word(KIND_FREE, 32'd0, blk_start[0] + HDR);      // double free, no merge
      send_word(KIND_FREE, 32'd0, blk_start[2] + HDR);
      send_word(KIND_FREE, 32'd0, blk_start[0] + HDR);      // double free that merges
      send_word(KIND_FREE, 32'd0, blk_start[1] + HDR);      // absorbed block is gone
      send_word(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);  // rounding overflow
      send_word(KIND_ALLOC, 32'hFFFF_FFF8, 32'h0000_0000);  // no fit, past the limit
      send_word(KIND_ALLOC, blk_size[0], 32'h0000_0000);    // exact fit, whole block
      send_word(KIND_ALLOC, 32'h8000_0000, 32'h0000_0000);  // high addresses
      wait_results_drained();
      // Limit lands exactly at the end of the next block
      set_heap_window(32'h0000_0000, carve_top + HDR + 64);
      send_word(KIND_ALLOC, 32'd64, 32'h0000_0000);
      send_word(KIND_ALLOC, 32'd1, 32'h0000_0000);
      wait_results_drained();
      set_heap_window(32'hFFFF_FFFF, 32'h0000_0000);
      send_word(KIND_ALLOC, 32'd8, 32'h0000_0000);
      wait_results_drained();
      // Base rewrite with blocks present keeps the carve pointer
      set_heap_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_ALLOC, 32'd8, 32'h0000_0000);
      send_word(KIND_FREE, 32'd0, blk_start[3] + HDR);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count,
                                      input logic [31:0] base, input logic [31:0] limit);
      wait_results_drained();
      set_heap_window(base, limit);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (count) send_random_item();
   endtask

   task automatic test_slot_table_full();
      int tries;
      wait_results_drained();
      set_heap_window(cfg_base, 32'hFFFF_FFFF);
      tx_idle_pct = 10;
      rx_idle_pct = 10;
      // Carve until every slot is taken, then ask for what nothing can hold
      for (tries = 0; tries < 80 && blk_count < SLOTS; tries++) begin
         send_word(KIND_ALLOC, 32'h0001_0000, $urandom);
      end
      send_word(KIND_ALLOC, 32'hFFFF_FFFF, $urandom);
      send_word(KIND_ALLOC, 32'hF000_0000, $urandom);
   endtask

   task automatic test_output_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // Stall the response side and keep offering, so the input backs up
      hold_toggle = ~hold_toggle;
      repeat (8) send_random_item();
   endtask

   task automatic test_drained_pause();
      repeat (5) begin
         wait_results_drained();
         send_random_item();
      end
   endtask

   // Stimulus: reset once, then each test in turn
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(15, 60, 480, $urandom,
                          (carve_top > 32'hFFFF_E000) ? 32'hFFFF_FFFF : carve_top + 4096);
      test_slot_table_full();
      test_random_traffic(60, 15, 480, 32'h0000_0000, 32'hFFFF_FFFF);
      test_output_backpressure();
      test_drained_pause();
      test_random_traffic(0, 0, 480, 32'hFFFF_FFFF, $urandom);
      wait_results_drained();
      // Give a stray late word time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Response ready: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : check_reply
      heap_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $error("response word %h with nothing expected", rsp_tdata);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata[31:0] !== want.address) begin
               $error("result_address: expected %h, got %h", want.address, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[34:32] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[34:32]);
               error_count++;
            end
            if (rsp_tdata[35] !== want.merged) begin
               $error("merged: expected %0d, got %0d", want.merged, rsp_tdata[35]);
               error_count++;
            end
         end
      end
   end

   // Watchdog: stop a hung run
   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== first_fit_heap_allocator_top.f =====
rtl/ffha_pkg.sv
rtl/ffha_round.sv
rtl/first_fit_heap_allocator_top.sv
test/first_fit_heap_allocator_top_tb.sv
